### src/iee_pkg.sv
// ----------------------------------------------------------------------------
// Infix evaluator package
// Shared widths, codes, payload types and a helper function for the evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package iee_pkg;

  // Number format: signed fixed point, VALUE_WIDTH bits in total.
  localparam int VALUE_WIDTH       = 32;
  localparam int DEF_FRACTION_BITS = 16;

  // Operator codes carried in the func field of an item.
  localparam logic [2:0] FN_START = 3'd0;
  localparam logic [2:0] FN_ADD   = 3'd1;
  localparam logic [2:0] FN_SUB   = 3'd2;
  localparam logic [2:0] FN_MUL   = 3'd3;
  localparam logic [2:0] FN_DIV   = 3'd4;
  localparam logic [2:0] FN_END   = 3'd5;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_NO_START = 2'd3;

  // Input and output items.
  typedef struct packed {
    logic [2:0]                    func;
    logic signed [VALUE_WIDTH-1:0] operand;
  } token_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [1:0]                    status;
  } result_t;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_ADD,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  // Request and response between the sequencer and the arithmetic unit.
  typedef struct packed {
    logic                          start;
    alu_op_t                       op;
    logic signed [VALUE_WIDTH-1:0] a;
    logic signed [VALUE_WIDTH-1:0] b;
    logic                          negate_b;
  } alu_req_t;

  typedef struct packed {
    logic                          done;
    logic signed [VALUE_WIDTH-1:0] result;
  } alu_rsp_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    T_IDLE,
    T_SUM,
    T_TERM,
    T_END
  } top_state_t;

  // Arithmetic unit states.
  typedef enum logic [2:0] {
    U_IDLE,
    U_ADD,
    U_MUL,
    U_DIV,
    U_SAT
  } unit_state_t;

  // Magnitude of a signed number; the most negative value maps to 2^(W-1).
  function automatic logic [VALUE_WIDTH-1:0] magnitude(logic signed [VALUE_WIDTH-1:0] x);
    logic [VALUE_WIDTH-1:0] u;
    u = x;
    return x[VALUE_WIDTH-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

`default_nettype wire

### src/iee_alu.sv
// ----------------------------------------------------------------------------
// Iterative arithmetic unit
// One shared adder serves a saturating add in one pass, a shift-and-add
// multiply over VALUE_WIDTH steps and a restoring divide over
// VALUE_WIDTH + FRACTION_BITS steps. Results are saturated to the signed range.
// ----------------------------------------------------------------------------
`default_nettype none

module iee_alu
  import iee_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  localparam int VW = VALUE_WIDTH;
  localparam int AW = VW + 2;
  localparam int PW = 2 * VW;
  localparam int DW = VW + FRACTION_BITS;
  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] MUL_LAST = CW'(VW - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);
  localparam logic [PW-1:0] DIV_MASK = {PW{1'b1}} >> (PW - DW);
  localparam logic [PW-1:0] LIM_NEG  = PW'(1) << (VW - 1);
  localparam logic [PW-1:0] LIM_POS  = LIM_NEG - PW'(1);

  unit_state_t state, state_next;

  logic [VW-1:0]        opr_x;
  logic [VW-1:0]        opr_y;
  logic [VW:0]          hi;
  logic [PW-1:0]        w;
  logic [CW-1:0]        cnt;
  logic                 neg;
  logic                 is_div;
  logic                 done;
  logic signed [VW-1:0] result;

  logic [AW-1:0] add_x;
  logic [AW-1:0] add_y;
  logic          add_sub;
  logic [AW-1:0] sum;
  logic [VW:0]   r2;
  logic          pos_ovf;
  logic          neg_ovf;
  logic [VW-1:0] add_sat;
  logic [PW-1:0] product;
  logic [PW-1:0] mag_full;
  logic [VW-1:0] neg_mag;
  logic [VW-1:0] sat_val;

  // Shared adder and its operand selection.
  always_comb begin
    r2      = {hi[VW-1:0], w[DW-1]};
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state)
      U_ADD: begin
        add_x   = {{2{opr_x[VW-1]}}, opr_x};
        add_y   = {{2{opr_y[VW-1]}}, opr_y};
        add_sub = neg;
      end
      U_MUL: begin
        add_x = {1'b0, hi};
        add_y = w[0] ? {2'b00, opr_x} : '0;
      end
      U_DIV: begin
        add_x   = {1'b0, r2};
        add_y   = {2'b00, opr_y};
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
    sum = add_x + (add_sub ? ~add_y : add_y) + AW'(add_sub);
  end

  // Saturation of the signed sum.
  always_comb begin
    pos_ovf = !sum[AW-1] && (sum[AW-2:VW-1] != '0);
    neg_ovf = sum[AW-1] && (sum[AW-2:VW-1] != '1);
    if (pos_ovf) begin
      add_sat = LIM_POS[VW-1:0];
    end else if (neg_ovf) begin
      add_sat = LIM_NEG[VW-1:0];
    end else begin
      add_sat = sum[VW-1:0];
    end
  end

  // Scaling and saturation of a product or quotient magnitude.
  always_comb begin
    product  = {hi[VW-1:0], w[VW-1:0]} >> FRACTION_BITS;
    mag_full = is_div ? (w & DIV_MASK) : product;
    neg_mag  = (mag_full > LIM_NEG) ? LIM_NEG[VW-1:0] : mag_full[VW-1:0];
    if (neg) begin
      sat_val = ~neg_mag + 1'b1;
    end else begin
      sat_val = (mag_full > LIM_POS) ? LIM_POS[VW-1:0] : mag_full[VW-1:0];
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      U_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            OP_ADD:  state_next = U_ADD;
            OP_MUL:  state_next = U_MUL;
            OP_DIV:  state_next = U_DIV;
            default: state_next = U_IDLE;
          endcase
        end
      end
      U_ADD: state_next = U_IDLE;
      U_MUL: begin
        if (cnt == MUL_LAST) begin
          state_next = U_SAT;
        end
      end
      U_DIV: begin
        if (cnt == DIV_LAST) begin
          state_next = U_SAT;
        end
      end
      U_SAT: state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  // Done flag, registered with the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == U_ADD) || (state == U_SAT);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      U_IDLE: begin
        if (req.start) begin
          cnt    <= '0;
          is_div <= (req.op == OP_DIV);
          neg    <= (req.op == OP_ADD) ? req.negate_b : (req.a[VW-1] ^ req.b[VW-1]);
          hi     <= '0;
          opr_x  <= (req.op == OP_ADD) ? req.a : magnitude(req.a);
          opr_y  <= (req.op == OP_ADD) ? req.b : magnitude(req.b);
          if (req.op == OP_DIV) begin
            w <= {{VW{1'b0}}, magnitude(req.a)} << FRACTION_BITS;
          end else begin
            w <= {{VW{1'b0}}, magnitude(req.b)};
          end
        end
      end
      U_ADD: result <= add_sat;
      U_MUL: begin
        hi          <= {1'b0, sum[VW:1]};
        w[VW-1:0]   <= {sum[0], w[VW-1:1]};
        cnt         <= cnt + 1'b1;
      end
      U_DIV: begin
        hi  <= sum[AW-1] ? r2 : sum[VW:0];
        w   <= {w[PW-2:0], !sum[AW-1]};
        cnt <= cnt + 1'b1;
      end
      U_SAT: result <= sat_val;
      default: begin
      end
    endcase
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

`default_nettype wire

### src/infix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// Infix expression evaluator
// Evaluates a flat expression with * and / above + and -, in signed fixed
// point. The token channel takes one operator and number per item; the result
// channel gives one value and status for each end item.
// Both channels use valid and stall; an item moves on a clock edge with valid
// high and stall low. Start, invalid codes and ignored operators do not use
// the arithmetic unit. Add and subtract, multiply, divide and the final sum of
// an end run on the shared shift-add or shift-subtract unit, whose step count
// sets their timing; numbers are Q16.16 with the default FRACTION_BITS.
// An end with a pending error answers at once without the unit.
// While the unit works, token_stall is high. A result waits in its output
// register while result_stall is high; then only a new token is held back.
// Synchronous reset clears the sum, the term, the start flag, the error code
// and any waiting result.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_expression_evaluator
  import iee_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   token_valid,
  output logic        token_stall,
  input  wire token_t token,
  output logic        result_valid,
  input  wire logic   result_stall,
  output result_t     result
);

  localparam int VW = VALUE_WIDTH;

  top_state_t state, state_next;

  logic signed [VW-1:0] running_sum;
  logic signed [VW-1:0] product_term;
  logic                 term_negative;
  logic                 started;
  logic [1:0]           error_code;
  logic signed [VW-1:0] pend_operand;
  logic                 pend_sub;

  logic     accept;
  logic     can_op;
  logic     emit;
  alu_req_t req;
  alu_rsp_t rsp;

  iee_alu #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_alu (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  assign token_stall = (state != T_IDLE) || (result_valid && result_stall);
  assign accept      = token_valid && !token_stall;
  assign can_op      = started && (error_code == ST_OK);

  // A result item is loaded at once for an end that cannot be evaluated, or
  // when the unit returns the final sum.
  assign emit = (accept && (token.func == FN_END) && !can_op) ||
                (rsp.done && (state == T_END));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and requests to the arithmetic unit.
  always_comb begin
    state_next   = state;
    req.start    = 1'b0;
    req.op       = OP_ADD;
    req.a        = running_sum;
    req.b        = product_term;
    req.negate_b = term_negative;
    unique case (state)
      T_IDLE: begin
        if (accept) begin
          unique case (token.func)
            FN_END: begin
              if (can_op) begin
                req.start  = 1'b1;
                state_next = T_END;
              end
            end
            FN_ADD, FN_SUB: begin
              if (can_op) begin
                req.start  = 1'b1;
                state_next = T_SUM;
              end
            end
            FN_MUL: begin
              if (can_op) begin
                req.start  = 1'b1;
                req.op     = OP_MUL;
                req.a      = product_term;
                req.b      = token.operand;
                state_next = T_TERM;
              end
            end
            FN_DIV: begin
              if (can_op && (token.operand != '0)) begin
                req.start  = 1'b1;
                req.op     = OP_DIV;
                req.a      = product_term;
                req.b      = token.operand;
                state_next = T_TERM;
              end
            end
            default: begin
            end
          endcase
        end
      end
      T_SUM, T_TERM, T_END: begin
        if (rsp.done) begin
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  // Expression state, error tracking and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      product_term  <= '0;
      term_negative <= 1'b0;
      started       <= 1'b0;
      error_code    <= ST_OK;
      result_valid  <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        unique case (token.func)
          FN_START: begin
            running_sum   <= '0;
            product_term  <= token.operand;
            term_negative <= 1'b0;
            started       <= 1'b1;
          end
          FN_END: begin
            // An error or a missing start answers at once with value zero.
            if (!can_op) begin
              result.value  <= '0;
              result.status <= (error_code != ST_OK) ? error_code : ST_NO_START;
            end
            running_sum   <= '0;
            product_term  <= '0;
            term_negative <= 1'b0;
            started       <= 1'b0;
            error_code    <= ST_OK;
          end
          FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
            if (!started) begin
              if (error_code == ST_OK) begin
                error_code <= ST_NO_START;
              end
            end else if (error_code == ST_OK) begin
              pend_operand <= token.operand;
              pend_sub     <= (token.func == FN_SUB);
              if ((token.func == FN_DIV) && (token.operand == '0)) begin
                error_code <= ST_DIV_ZERO;
              end
            end
          end
          default: begin
            if (error_code == ST_OK) begin
              error_code <= ST_INVALID;
            end
          end
        endcase
      end
      // Results coming back from the arithmetic unit.
      if (rsp.done) begin
        unique case (state)
          T_SUM: begin
            running_sum   <= rsp.result;
            product_term  <= pend_operand;
            term_negative <= pend_sub;
          end
          T_TERM: product_term <= rsp.result;
          T_END: begin
            result.value  <= rsp.result;
            result.status <= ST_OK;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire
